[rtl/core/psag_pkg.sv]
// ----------------------------------------------------------------------------
// psag_pkg
// Shared constants and types of the pixel shuffle address generator.
// ----------------------------------------------------------------------------
package psag_pkg;

   localparam int ADDR_BITS_DEFAULT = 24;
   localparam int DATA_BITS_DEFAULT = 32;

   // the data word is passed through at no more than this many bits
   localparam int WORD_KEEP_BITS = 32;

   // register port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 13;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIRECTION = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BATCH     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNELS  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH     = 3'd5;

   // address arithmetic: multiply operand and addend widths, steps per item
   localparam int MUL_BITS  = 14;
   localparam int ADD_BITS  = 13;
   localparam int MAC_STEPS = 3;

   // depth of the queue between front and back, a power of two
   localparam int QUEUE_DEPTH = 4;

   // tensor shape after clamping, held stable while items stream
   typedef struct packed {
      logic        dir;
      logic [3:0]  r;
      logic [6:0]  rr;
      logic [6:0]  nb;
      logic [12:0] c_lo;
      logic [12:0] c_hi;
      logic [10:0] h_lo;
      logic [13:0] h_hi;
      logic [10:0] w_lo;
      logic [13:0] w_hi;
      logic        shape_err;
   } shape_type;

   // one classified item: batch index and the three addends of the address
   typedef struct packed {
      logic [5:0]  n;
      logic [11:0] b;
      logic [12:0] d;
      logic [12:0] e;
      logic        last;
   } job_type;

endpackage

[rtl/core/psag_queue.sv]
// ----------------------------------------------------------------------------
// psag_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module psag_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int DEPTH    = psag_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = $clog2(DEPTH);

   logic [WIDTH-1:0]  mem [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic                push_ok, pop_ok;

   assign full    = (count_ff == (PTR_BITS+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rdata   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[rtl/core/psag_front.sv]
// ----------------------------------------------------------------------------
// psag_front
// Register file, shape setup and position counters; classifies each item.
// ----------------------------------------------------------------------------
module psag_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [psag_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [psag_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                  q_full,
   output logic                                  q_push,
   output psag_pkg::job_type                     q_job,
   output psag_pkg::shape_type                   shape
);

   localparam int DIV_STEPS = 13;
   localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);

   // registers as written
   logic        dir_ff, dir_in;
   logic [3:0]  scale_ff, scale_in;
   logic [6:0]  batch_ff, batch_in;
   logic [12:0] chan_ff, chan_in;
   logic [10:0] height_ff, height_in;
   logic [10:0] width_ff, width_in;
   logic        cfg_hit;

   // clamped shape
   logic [3:0]  r_cl;
   logic [6:0]  nb_cl;
   logic [12:0] c_cl;
   logic [10:0] h_cl;
   logic [10:0] w_cl;
   psag_pkg::shape_type shape_ff, shape_in;

   // channel count divided by r*r
   logic                div_load_ff;
   logic [CNT_BITS-1:0] div_cnt_ff;
   logic [12:0]         div_num_ff, div_num_in;
   logic [6:0]          div_rem_ff, div_rem_in;
   logic [7:0]          rem_try;
   logic                rem_ge;
   logic                busy;

   // positions and their digits
   logic [5:0]  n_ff, n_in;
   logic [11:0] c_ff, c_in;
   logic [12:0] h_ff, h_in;
   logic [12:0] w_ff, w_in;
   logic [2:0]  c0_ff, c0_in, c1_ff, c1_in;
   logic [11:0] cq_ff, cq_in, cs_ff, cs_in;
   logic [2:0]  hr_ff, hr_in, wr_ff, wr_in;
   logic [9:0]  hq_ff, hq_in, wq_ff, wq_in;
   logic [12:0] hs_ff, hs_in, ws_ff, ws_in;

   logic [12:0] lim_c;
   logic [13:0] lim_h, lim_w;
   logic        n_last, c_last, h_last, w_last;
   logic [2:0]  r_m1;
   logic [6:0]  hrr;
   logic        push_ok;

   assign csr_ready = 1'b1;

   always_comb begin
      dir_in    = dir_ff;
      scale_in  = scale_ff;
      batch_in  = batch_ff;
      chan_in   = chan_ff;
      height_in = height_ff;
      width_in  = width_ff;
      cfg_hit   = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            psag_pkg::CSR_DIRECTION: begin
               dir_in  = csr_data[0];
               cfg_hit = 1'b1;
            end
            psag_pkg::CSR_SCALE: begin
               scale_in = csr_data[3:0];
               cfg_hit  = 1'b1;
            end
            psag_pkg::CSR_BATCH: begin
               batch_in = csr_data[6:0];
               cfg_hit  = 1'b1;
            end
            psag_pkg::CSR_CHANNELS: begin
               chan_in = csr_data[12:0];
               cfg_hit = 1'b1;
            end
            psag_pkg::CSR_HEIGHT: begin
               height_in = csr_data[10:0];
               cfg_hit   = 1'b1;
            end
            psag_pkg::CSR_WIDTH: begin
               width_in = csr_data[10:0];
               cfg_hit  = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      r_cl  = (scale_ff == 4'd0) ? 4'd1 : ((scale_ff > 4'd8) ? 4'd8 : scale_ff);
      nb_cl = (batch_ff == 7'd0) ? 7'd1 : ((batch_ff > 7'd64) ? 7'd64 : batch_ff);
      c_cl  = (chan_ff == 13'd0) ? 13'd1 : ((chan_ff > 13'd4096) ? 13'd4096 : chan_ff);
      h_cl  = (height_ff == 11'd0) ? 11'd1 : ((height_ff > 11'd1024) ? 11'd1024 : height_ff);
      w_cl  = (width_ff == 11'd0) ? 11'd1 : ((width_ff > 11'd1024) ? 11'd1024 : width_ff);

      shape_in           = '0;
      shape_in.dir       = dir_ff;
      shape_in.r         = r_cl;
      shape_in.rr        = {3'b000, r_cl} * {3'b000, r_cl};
      shape_in.nb        = nb_cl;
      shape_in.c_lo      = c_cl;
      shape_in.h_lo      = h_cl;
      shape_in.h_hi      = {3'b000, h_cl} * {10'd0, r_cl};
      shape_in.w_lo      = w_cl;
      shape_in.w_hi      = {3'b000, w_cl} * {10'd0, r_cl};
   end

   // quotient and remainder come straight from the divider registers
   always_comb begin
      shape           = shape_ff;
      shape.c_hi      = div_num_ff;
      shape.shape_err = (div_rem_ff != 7'd0);
   end

   // restoring division, one quotient bit a cycle
   always_comb begin
      rem_try    = {div_rem_ff, div_num_ff[12]};
      rem_ge     = (rem_try >= {1'b0, shape_ff.rr});
      div_rem_in = rem_ge ? 7'(rem_try - {1'b0, shape_ff.rr}) : rem_try[6:0];
      div_num_in = {div_num_ff[11:0], rem_ge};
   end

   assign busy     = div_load_ff || (div_cnt_ff != '0);
   assign req_full = busy || q_full;
   assign push_ok  = req_push && !req_full;
   assign q_push   = push_ok;

   always_comb begin
      lim_c  = shape.dir ? ((shape.c_hi == 13'd0) ? 13'd1 : shape.c_hi) : shape.c_lo;
      lim_h  = shape.dir ? shape.h_hi : {3'b000, shape.h_lo};
      lim_w  = shape.dir ? shape.w_hi : {3'b000, shape.w_lo};
      n_last = (({1'b0, n_ff} + 7'd1) >= shape.nb);
      c_last = (({1'b0, c_ff} + 13'd1) >= lim_c);
      h_last = (({1'b0, h_ff} + 14'd1) >= lim_h);
      w_last = (({1'b0, w_ff} + 14'd1) >= lim_w);
      r_m1   = 3'(shape.r - 4'd1);
      hrr    = {4'b0000, hr_ff} * {3'b000, shape.r};
   end

   // classify: depth-to-space needs c/rr, (c/r)%r, c%r with h*r and w*r;
   // space-to-depth needs c*rr, h%r, w%r, h/r and w/r
   always_comb begin
      q_job      = '0;
      q_job.n    = n_ff;
      q_job.last = n_last && c_last && h_last && w_last;
      if (shape.dir) begin
         q_job.b = 12'({1'b0, cs_ff} + {6'd0, hrr} + {10'd0, wr_ff});
         q_job.d = {3'b000, hq_ff};
         q_job.e = {3'b000, wq_ff};
      end else begin
         q_job.b = cq_ff;
         q_job.d = hs_ff + {10'd0, c1_ff};
         q_job.e = ws_ff + {10'd0, c0_ff};
      end
   end

   always_comb begin
      n_in  = n_ff;
      c_in  = c_ff;
      c0_in = c0_ff;
      c1_in = c1_ff;
      cq_in = cq_ff;
      cs_in = cs_ff;
      h_in  = h_ff;
      hr_in = hr_ff;
      hq_in = hq_ff;
      hs_in = hs_ff;
      w_in  = w_ff;
      wr_in = wr_ff;
      wq_in = wq_ff;
      ws_in = ws_ff;
      if (cfg_hit) begin
         n_in  = '0;
         c_in  = '0;
         c0_in = '0;
         c1_in = '0;
         cq_in = '0;
         cs_in = '0;
         h_in  = '0;
         hr_in = '0;
         hq_in = '0;
         hs_in = '0;
         w_in  = '0;
         wr_in = '0;
         wq_in = '0;
         ws_in = '0;
      end else if (push_ok) begin
         if (!w_last) begin
            w_in  = w_ff + 13'd1;
            ws_in = ws_ff + {9'd0, shape.r};
            if (wr_ff == r_m1) begin
               wr_in = '0;
               wq_in = wq_ff + 10'd1;
            end else begin
               wr_in = wr_ff + 3'd1;
            end
         end else begin
            w_in  = '0;
            wr_in = '0;
            wq_in = '0;
            ws_in = '0;
            if (!h_last) begin
               h_in  = h_ff + 13'd1;
               hs_in = hs_ff + {9'd0, shape.r};
               if (hr_ff == r_m1) begin
                  hr_in = '0;
                  hq_in = hq_ff + 10'd1;
               end else begin
                  hr_in = hr_ff + 3'd1;
               end
            end else begin
               h_in  = '0;
               hr_in = '0;
               hq_in = '0;
               hs_in = '0;
               if (!c_last) begin
                  c_in  = c_ff + 12'd1;
                  cs_in = cs_ff + {5'd0, shape.rr};
                  if (c0_ff == r_m1) begin
                     c0_in = '0;
                     if (c1_ff == r_m1) begin
                        c1_in = '0;
                        cq_in = cq_ff + 12'd1;
                     end else begin
                        c1_in = c1_ff + 3'd1;
                     end
                  end else begin
                     c0_in = c0_ff + 3'd1;
                  end
               end else begin
                  c_in  = '0;
                  c0_in = '0;
                  c1_in = '0;
                  cq_in = '0;
                  cs_in = '0;
                  n_in  = n_last ? 6'd0 : n_ff + 6'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff      <= 1'b0;
         scale_ff    <= 4'd2;
         batch_ff    <= 7'd1;
         chan_ff     <= 13'd4;
         height_ff   <= 11'd1;
         width_ff    <= 11'd1;
         div_load_ff <= 1'b1;
         div_cnt_ff  <= '0;
         n_ff        <= '0;
         c_ff        <= '0;
         c0_ff       <= '0;
         c1_ff       <= '0;
         cq_ff       <= '0;
         cs_ff       <= '0;
         h_ff        <= '0;
         hr_ff       <= '0;
         hq_ff       <= '0;
         hs_ff       <= '0;
         w_ff        <= '0;
         wr_ff       <= '0;
         wq_ff       <= '0;
         ws_ff       <= '0;
      end else begin
         dir_ff      <= dir_in;
         scale_ff    <= scale_in;
         batch_ff    <= batch_in;
         chan_ff     <= chan_in;
         height_ff   <= height_in;
         width_ff    <= width_in;
         div_load_ff <= cfg_hit;
         if (div_load_ff) begin
            div_cnt_ff <= CNT_BITS'(DIV_STEPS);
         end else if (div_cnt_ff != '0) begin
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end
         n_ff  <= n_in;
         c_ff  <= c_in;
         c0_ff <= c0_in;
         c1_ff <= c1_in;
         cq_ff <= cq_in;
         cs_ff <= cs_in;
         h_ff  <= h_in;
         hr_ff <= hr_in;
         hq_ff <= hq_in;
         hs_ff <= hs_in;
         w_ff  <= w_in;
         wr_ff <= wr_in;
         wq_ff <= wq_in;
         ws_ff <= ws_in;
      end
   end

   // the dividend is taken from the clamped registers in the cycle after a write
   always_ff @(posedge clock) begin
      shape_ff <= shape_in;
      if (div_load_ff) begin
         div_num_ff <= c_cl;
         div_rem_ff <= '0;
      end else if (div_cnt_ff != '0) begin
         div_num_ff <= div_num_in;
         div_rem_ff <= div_rem_in;
      end
   end

endmodule

[rtl/core/psag_back.sv]
// ----------------------------------------------------------------------------
// psag_back
// Address sequencer: three multiply-add steps on one multiplier, then the
// result register.
// ----------------------------------------------------------------------------
module psag_back #(
   parameter int ADDR_BITS = psag_pkg::ADDR_BITS_DEFAULT,
   parameter int DATA_BITS = psag_pkg::DATA_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  logic [DATA_BITS-1:0]  q_word,
   input  psag_pkg::job_type     q_job,
   input  psag_pkg::shape_type   shape,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [DATA_BITS-1:0]  rsp_moved_word,
   output logic [ADDR_BITS-1:0]  rsp_dest_address,
   output logic                  rsp_last_element,
   output logic                  rsp_shape_error
);

   localparam int MUL_BITS  = psag_pkg::MUL_BITS;
   localparam int ADD_BITS  = psag_pkg::ADD_BITS;
   localparam int PW        = ADDR_BITS + MUL_BITS;
   localparam int SUM_BITS  = PW + 1;
   localparam int STEP_BITS = $clog2(psag_pkg::MAC_STEPS);
   localparam int KEEP_BITS = (DATA_BITS < psag_pkg::WORD_KEEP_BITS) ?
                              DATA_BITS : psag_pkg::WORD_KEEP_BITS;
   localparam logic [DATA_BITS-1:0] WORD_MASK = {DATA_BITS{1'b1}} >> (DATA_BITS - KEEP_BITS);

   localparam logic [STEP_BITS-1:0] STEP_CHAN = STEP_BITS'(0);
   localparam logic [STEP_BITS-1:0] STEP_ROW  = STEP_BITS'(1);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(psag_pkg::MAC_STEPS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_ADD,
      S_SEND
   } state_type;

   state_type             state_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [ADDR_BITS-1:0]  x_ff;
   logic                  ovf_ff;
   logic [PW-1:0]         prod_ff;
   logic [DATA_BITS-1:0]  word_ff;
   psag_pkg::job_type     job_ff;
   logic                  out_valid_ff;
   logic [DATA_BITS-1:0]  out_word_ff;
   logic [ADDR_BITS-1:0]  out_addr_ff;
   logic                  out_last_ff;
   logic                  out_err_ff;

   logic [MUL_BITS-1:0]   m_sel;
   logic [ADD_BITS-1:0]   a_sel;
   logic [PW-1:0]         prod_calc;
   logic [SUM_BITS-1:0]   sum_calc;
   logic                  out_free;
   logic                  out_load;

   // address = ((n*A + b)*B + d)*C + e, one factor per step
   always_comb begin
      case (step_ff)
         STEP_CHAN: begin
            m_sel = shape.dir ? {1'b0, shape.c_lo} : {1'b0, shape.c_hi};
            a_sel = {1'b0, job_ff.b};
         end
         STEP_ROW: begin
            m_sel = shape.dir ? {3'b000, shape.h_lo} : shape.h_hi;
            a_sel = job_ff.d;
         end
         default: begin
            m_sel = shape.dir ? {3'b000, shape.w_lo} : shape.w_hi;
            a_sel = job_ff.e;
         end
      endcase
      prod_calc = {{MUL_BITS{1'b0}}, x_ff} * {{ADDR_BITS{1'b0}}, m_sel};
      sum_calc  = {1'b0, prod_ff} + {{(SUM_BITS-ADD_BITS){1'b0}}, a_sel};
   end

   assign out_free = !out_valid_ff || rsp_pop;
   assign out_load = (state_ff == S_SEND) && out_free;
   assign q_pop    = !q_empty && ((state_ff == S_IDLE) || ((state_ff == S_SEND) && out_free));

   assign rsp_empty        = !out_valid_ff;
   assign rsp_moved_word   = out_word_ff;
   assign rsp_dest_address = out_addr_ff;
   assign rsp_last_element = out_last_ff;
   assign rsp_shape_error  = out_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_load || (out_valid_ff && !rsp_pop);
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  word_ff  <= q_word;
                  job_ff   <= q_job;
                  x_ff     <= ADDR_BITS'(q_job.n);
                  ovf_ff   <= 1'b0;
                  step_ff  <= STEP_CHAN;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= prod_calc;
               state_ff <= S_ADD;
            end
            S_ADD: begin
               x_ff   <= sum_calc[ADDR_BITS-1:0];
               // once past the range it stays past: the later factors are at least one
               ovf_ff <= ovf_ff || (sum_calc[SUM_BITS-1:ADDR_BITS] != '0);
               if (step_ff == STEP_LAST) begin
                  state_ff <= S_SEND;
               end else begin
                  step_ff  <= step_ff + 1'b1;
                  state_ff <= S_MUL;
               end
            end
            S_SEND: begin
               if (out_free) begin
                  out_word_ff  <= word_ff & WORD_MASK;
                  out_addr_ff  <= ovf_ff ? {ADDR_BITS{1'b1}} : x_ff;
                  out_last_ff  <= job_ff.last;
                  out_err_ff   <= ovf_ff || shape.shape_err;
                  if (!q_empty) begin
                     word_ff  <= q_word;
                     job_ff   <= q_job;
                     x_ff     <= ADDR_BITS'(q_job.n);
                     ovf_ff   <= 1'b0;
                     step_ff  <= STEP_CHAN;
                     state_ff <= S_MUL;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

[rtl/core/pixel_shuffle_address_gen.sv]
// ----------------------------------------------------------------------------
// pixel_shuffle_address_gen
// Takes tensor elements in source NCHW order and returns each data word with
// its linear address in the pixel-shuffled tensor (depth-to-space when
// direction is 0, space-to-depth when 1). The front accepts an item every
// cycle while req_full is low, into a four-entry queue; the back finishes
// one item before it takes the next, paced by its single shared multiplier,
// which runs three multiply-add steps, each a multiply state then an add
// state, then a send state that hands the result to the output register.
// After reset and after every write to a shape register req_full stays high
// while the channel count is divided by r*r. Addresses beyond ADDR_BITS
// saturate to all ones and set shape_error, which is also set on every item
// when the channel count is not a multiple of r*r.
// ----------------------------------------------------------------------------
module pixel_shuffle_address_gen #(
   parameter int ADDR_BITS = psag_pkg::ADDR_BITS_DEFAULT,
   parameter int DATA_BITS = psag_pkg::DATA_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [DATA_BITS-1:0]                 req_element_word,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [DATA_BITS-1:0]                 rsp_moved_word,
   output logic [ADDR_BITS-1:0]                 rsp_dest_address,
   output logic                                 rsp_last_element,
   output logic                                 rsp_shape_error,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [psag_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [psag_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int JOB_BITS = $bits(psag_pkg::job_type);
   localparam int Q_BITS   = DATA_BITS + JOB_BITS;

   psag_pkg::job_type   front_job;
   psag_pkg::shape_type shape;
   logic                q_push, q_full, q_pop, q_empty;
   logic [Q_BITS-1:0]   q_wdata, q_rdata;

   psag_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (front_job),
      .shape     (shape)
   );

   assign q_wdata = {req_element_word, front_job};

   psag_queue #(
      .WIDTH (Q_BITS)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   psag_back #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .q_word           (q_rdata[Q_BITS-1:JOB_BITS]),
      .q_job            (psag_pkg::job_type'(q_rdata[JOB_BITS-1:0])),
      .shape            (shape),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_moved_word   (rsp_moved_word),
      .rsp_dest_address (rsp_dest_address),
      .rsp_last_element (rsp_last_element),
      .rsp_shape_error  (rsp_shape_error)
   );

endmodule

[rtl/core/psag_checker.sv]
// ----------------------------------------------------------------------------
// psag_checker
// Port-level checks of the pixel shuffle address generator, bound to the top.
// ----------------------------------------------------------------------------
module psag_checker #(
   parameter int ADDR_BITS = psag_pkg::ADDR_BITS_DEFAULT,
   parameter int DATA_BITS = psag_pkg::DATA_BITS_DEFAULT
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_full,
   input logic                                 rsp_empty,
   input logic                                 rsp_pop,
   input logic [DATA_BITS-1:0]                 rsp_moved_word,
   input logic [ADDR_BITS-1:0]                 rsp_dest_address,
   input logic                                 rsp_last_element,
   input logic                                 rsp_shape_error,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [psag_pkg::CSR_INDEX_BITS-1:0]  csr_index
);

   // nothing is waiting right after reset
   a_reset_empty : assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown right after reset");

   // setup division holds off items after reset
   a_reset_full : assert property (@(posedge clock) reset |=> req_full)
      else $error("input open before shape setup");

   // a write to a shape register restarts the setup and closes the input
   a_csr_restart : assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && (csr_index <= psag_pkg::CSR_WIDTH)) |=> req_full)
      else $error("input open straight after a register write");

   // a waiting result holds until taken
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_moved_word) && $stable(rsp_dest_address) &&
          $stable(rsp_last_element) && $stable(rsp_shape_error)))
      else $error("waiting result changed or vanished");

endmodule

bind pixel_shuffle_address_gen psag_checker #(
   .ADDR_BITS (ADDR_BITS),
   .DATA_BITS (DATA_BITS)
) u_psag_checker (.*);

[sim/pixel_shuffle_address_gen_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_shuffle_address_gen_tb
// Streams tensor elements through the address generator under a range of
// shapes, scale factors and directions, predicts the destination address,
// tensor end and error flag of every element, and compares each result as it
// is popped. Covers register clamping, ragged channel counts, addresses high
// in the range, a long output stall and random idling on both sides.
// ----------------------------------------------------------------------------
module pixel_shuffle_address_gen_tb;

   localparam int ADDR_BITS = psag_pkg::ADDR_BITS_DEFAULT;
   localparam int DATA_BITS = psag_pkg::DATA_BITS_DEFAULT;
   localparam longint unsigned ADDR_LIMIT = (64'd1 << ADDR_BITS) - 64'd1;

   localparam logic [psag_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [psag_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_HIGH = 3'd7;

   localparam int RESET_CYCLES    = 6;
   localparam int SETTLE_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_ITEMS     = 200;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [DATA_BITS-1:0] word;
      logic [ADDR_BITS-1:0] address;
      logic                 last;
      logic                 error;
   } placed_type;

   typedef struct {
      longint unsigned r;
      longint unsigned nb;
      longint unsigned cl;
      longint unsigned hl;
      longint unsigned wl;
   } geometry_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_push = 1'b0;
   logic                                req_full;
   logic [DATA_BITS-1:0]                req_element_word = '0;
   logic                                rsp_empty;
   logic                                rsp_pop = 1'b0;
   logic [DATA_BITS-1:0]                rsp_moved_word;
   logic [ADDR_BITS-1:0]                rsp_dest_address;
   logic                                rsp_last_element;
   logic                                rsp_shape_error;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [psag_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [psag_pkg::CSR_DATA_BITS-1:0]  csr_data = '0;

   // shape registers as last written, and the walk position
   logic        shape_dir      = 1'b0;
   logic [3:0]  shape_scale    = 4'd2;
   logic [6:0]  shape_batch    = 7'd1;
   logic [12:0] shape_channels = 13'd4;
   logic [10:0] shape_height   = 11'd1;
   logic [10:0] shape_width    = 11'd1;
   logic [5:0]  at_batch   = '0;
   logic [11:0] at_channel = '0;
   logic [12:0] at_row     = '0;
   logic [12:0] at_col     = '0;

   placed_type expected_moves[$];

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int hold_request   = 0;
   int hold_left      = 0;
   int idle_cycles    = 0;
   int fail_count     = 0;
   int items_sent     = 0;
   int results_seen   = 0;
   int error_results  = 0;
   int saturated_seen = 0;
   int tensor_ends    = 0;
   int shapes_used    = 0;

   pixel_shuffle_address_gen #(
      .ADDR_BITS(ADDR_BITS),
      .DATA_BITS(DATA_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_element_word(req_element_word),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_moved_word  (rsp_moved_word),
      .rsp_dest_address(rsp_dest_address),
      .rsp_last_element(rsp_last_element),
      .rsp_shape_error (rsp_shape_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned clamp_to(input longint unsigned v,
                                                input longint unsigned lo,
                                                input longint unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic geometry_type clamped_geometry();
      geometry_type g;
      g.r  = clamp_to(shape_scale, 1, 8);
      g.nb = clamp_to(shape_batch, 1, 64);
      g.cl = clamp_to(shape_channels, 1, 4096);
      g.hl = clamp_to(shape_height, 1, 1024);
      g.wl = clamp_to(shape_width, 1, 1024);
      return g;
   endfunction

   // destination of the element at the current position, then step the walk
   function automatic placed_type place_element(input logic [DATA_BITS-1:0] word);
      geometry_type g;
      longint unsigned rr, c_hi, h_hi, w_hi, n, c, h, w;
      longint unsigned lim_c, lim_h, lim_w, addr;
      logic bad;
      placed_type res;
      g    = clamped_geometry();
      rr   = g.r * g.r;
      c_hi = g.cl / rr;
      h_hi = g.hl * g.r;
      w_hi = g.wl * g.r;
      bad  = (g.cl % rr) != 0;
      n = at_batch;
      c = at_channel;
      h = at_row;
      w = at_col;
      if (!shape_dir) begin
         lim_c = g.cl;
         lim_h = g.hl;
         lim_w = g.wl;
         addr = n * (c_hi * h_hi * w_hi) + (c / rr) * (h_hi * w_hi)
              + (h * g.r + (c / g.r) % g.r) * w_hi + (w * g.r + c % g.r);
      end else begin
         // source channel count rounds down but never below one
         lim_c = (c_hi != 0) ? c_hi : 1;
         lim_h = h_hi;
         lim_w = w_hi;
         addr = n * (g.cl * g.hl * g.wl)
              + (c * rr + (h % g.r) * g.r + w % g.r) * (g.hl * g.wl)
              + (h / g.r) * g.wl + w / g.r;
      end
      if (addr > ADDR_LIMIT) begin
         addr = ADDR_LIMIT;
         bad  = 1'b1;
      end
      res.word    = word;
      res.address = addr[ADDR_BITS-1:0];
      res.last    = (n + 1 >= g.nb) && (c + 1 >= lim_c) && (h + 1 >= lim_h) &&
                    (w + 1 >= lim_w);
      res.error   = bad;
      if (w + 1 < lim_w) begin
         at_col = 13'(w + 1);
      end else begin
         at_col = '0;
         if (h + 1 < lim_h) begin
            at_row = 13'(h + 1);
         end else begin
            at_row = '0;
            if (c + 1 < lim_c) begin
               at_channel = 12'(c + 1);
            end else begin
               at_channel = '0;
               at_batch   = (n + 1 < g.nb) ? 6'(n + 1) : '0;
            end
         end
      end
      return res;
   endfunction

   // offers one element and records its expected placement once taken
   task automatic send_element(input logic [DATA_BITS-1:0] word);
      placed_type next_move;
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push         <= 1'b1;
      req_element_word <= word;
      @(posedge clock);
      while (req_full) @(posedge clock);
      next_move      = place_element(word);
      expected_moves = {expected_moves, next_move};
      items_sent++;
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (expected_moves.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes need no gap
   task automatic write_register(input logic [psag_pkg::CSR_INDEX_BITS-1:0] index,
                                 input logic [psag_pkg::CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         psag_pkg::CSR_DIRECTION: shape_dir      = value[0];
         psag_pkg::CSR_SCALE:     shape_scale    = value[3:0];
         psag_pkg::CSR_BATCH:     shape_batch    = value[6:0];
         psag_pkg::CSR_CHANNELS:  shape_channels = value;
         psag_pkg::CSR_HEIGHT:    shape_height   = value[10:0];
         psag_pkg::CSR_WIDTH:     shape_width    = value[10:0];
         default: ;
      endcase
      // unused indexes leave the walk where it is
      if (index <= psag_pkg::CSR_WIDTH) begin
         at_batch   = '0;
         at_channel = '0;
         at_row     = '0;
         at_col     = '0;
      end
   endtask

   task automatic write_shape(input logic [psag_pkg::CSR_DATA_BITS-1:0] dir,
                              input logic [psag_pkg::CSR_DATA_BITS-1:0] scale,
                              input logic [psag_pkg::CSR_DATA_BITS-1:0] batch,
                              input logic [psag_pkg::CSR_DATA_BITS-1:0] chans,
                              input logic [psag_pkg::CSR_DATA_BITS-1:0] rows,
                              input logic [psag_pkg::CSR_DATA_BITS-1:0] cols);
      drain_results();
      write_register(psag_pkg::CSR_DIRECTION, dir);
      write_register(psag_pkg::CSR_SCALE, scale);
      write_register(psag_pkg::CSR_BATCH, batch);
      write_register(psag_pkg::CSR_CHANNELS, chans);
      write_register(psag_pkg::CSR_HEIGHT, rows);
      write_register(psag_pkg::CSR_WIDTH, cols);
      csr_valid <= 1'b0;
      shapes_used++;
   endtask

   // reset shape: four channels, one pixel, depth-to-space at r=2
   task automatic test_default_shape();
      send_element('0);
      send_element('1);
      send_element(32'hAAAA_AAAA);
      send_element(32'h5555_5555);
      send_element(32'h0F0F_F0F0);
      drain_results();
      write_register(CSR_SPARE_LOW, 13'h1555);
      write_register(CSR_SPARE_HIGH, 13'h0AAA);
      csr_valid <= 1'b0;
      repeat (3) send_element($urandom);
   endtask

   // zero and all-ones register writes clamp to the range ends
   task automatic test_register_extremes();
      write_shape(13'h1FFE, '0, '0, '0, '0, '0);
      repeat (2) send_element($urandom);
      write_shape('1, '1, '1, '1, '1, '1);
      repeat (3) send_element($urandom);
      drain_results();
      write_register(psag_pkg::CSR_DIRECTION, '0);
      csr_valid <= 1'b0;
      repeat (3) send_element($urandom);
   endtask

   // channel counts that r*r does not divide, one of them below r*r
   task automatic test_shape_error();
      write_shape(13'd1, 13'd2, 13'd1, 13'd6, 13'd1, 13'd2);
      repeat (4) send_element($urandom);
      write_shape(13'd1, 13'd2, 13'd1, 13'd3, 13'd1, 13'd1);
      repeat (4) send_element($urandom);
   endtask

   // space-to-depth at r=8 on a 1024x1024 plane scatters high into the range
   task automatic test_large_plane();
      write_shape(13'd1, 13'd8, 13'd1, 13'd64, 13'd1024, 13'd1024);
      repeat (48) send_element($urandom);
   endtask

   // output held off while the input keeps offering, so req_full must rise
   task automatic test_backpressure();
      write_shape(13'd0, 13'd2, 13'd2, 13'd8, 13'd2, 13'd3);
      hold_request = HOLD_OFF_CYCLES;
      repeat (60) send_element($urandom);
   endtask

   task automatic test_random_shapes();
      int idle_mix[4]  = '{0, 49, 0, 17};
      int stall_mix[4] = '{0, 0, 49, 17};
      int phase, sent, count;
      geometry_type g;
      longint unsigned rr, total;
      logic [psag_pkg::CSR_DATA_BITS-1:0] v_scale, v_batch, v_chans, v_rows, v_cols;
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_mix[phase];
         rsp_stall_pct = stall_mix[phase];
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            // mostly small shapes that can be walked end to end
            if ($urandom_range(0, 9) < 8) v_scale = 13'($urandom_range(1, 3));
            else if ($urandom_range(0, 1) != 0) v_scale = 13'($urandom_range(1, 8));
            else v_scale = 13'($urandom_range(0, 8191));
            rr = clamp_to(v_scale[3:0], 1, 8) * clamp_to(v_scale[3:0], 1, 8);
            v_batch = ($urandom_range(0, 99) < 85) ? 13'($urandom_range(1, 2))
                                                   : 13'($urandom_range(0, 8191));
            case ($urandom_range(0, 19))
               0, 1, 2:     v_chans = 13'($urandom_range(1, 2 * rr));
               3, 4, 5:     v_chans = 13'($urandom_range(0, 8191));
               default:     v_chans = 13'(rr * $urandom_range(1, 2));
            endcase
            v_rows = ($urandom_range(0, 99) < 85) ? 13'($urandom_range(1, 3))
                                                  : 13'($urandom_range(0, 8191));
            v_cols = ($urandom_range(0, 99) < 85) ? 13'($urandom_range(1, 3))
                                                  : 13'($urandom_range(0, 8191));
            write_shape(13'($urandom_range(0, 8191)), v_scale, v_batch, v_chans,
                        v_rows, v_cols);
            g = clamped_geometry();
            if (!shape_dir) total = g.nb * g.cl * g.hl * g.wl;
            else total = g.nb * clamp_to(g.cl / rr, 1, 4096) * rr * g.hl * g.wl;
            if (total <= 150) count = int'(total) + $urandom_range(0, int'(total));
            else count = $urandom_range(20, 80);
            repeat (count) send_element($urandom);
            sent += count;
         end
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      placed_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (expected_moves.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("%0t: result with no item outstanding: word %h addr %h",
                        $realtime, rsp_moved_word, rsp_dest_address);
         end else begin
            want = expected_moves.pop_front();
            if (want.error) error_results++;
            if (want.error && want.address == ADDR_LIMIT[ADDR_BITS-1:0]) saturated_seen++;
            if (want.last) tensor_ends++;
            if (rsp_moved_word !== want.word || rsp_dest_address !== want.address ||
                rsp_last_element !== want.last || rsp_shape_error !== want.error) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: mismatch exp word %h addr %h last %b err %b, got %h %h %b %b",
                           $realtime, want.word, want.address, want.last, want.error,
                           rsp_moved_word, rsp_dest_address, rsp_last_element,
                           rsp_shape_error);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, expected_moves.size());
         $display("** pixel_shuffle_address_gen: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_default_shape();
      test_register_extremes();
      test_shape_error();
      test_large_plane();
      test_backpressure();
      test_random_shapes();
      drain_results();
      $display("covered %0d items over %0d shape settings, %0d results checked",
               items_sent, shapes_used, results_seen);
      $display("%0d with shape error, %0d saturated addresses, %0d tensor ends, %0d failures",
               error_results, saturated_seen, tensor_ends, fail_count);
      if (fail_count == 0 && expected_moves.size() == 0) begin
         $display("** pixel_shuffle_address_gen: PASSED **");
      end else begin
         $display("** pixel_shuffle_address_gen: FAILED **");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/psag_pkg.sv
rtl/core/psag_queue.sv
rtl/core/psag_front.sv
rtl/core/psag_back.sv
rtl/core/pixel_shuffle_address_gen.sv
rtl/core/psag_checker.sv
sim/pixel_shuffle_address_gen_tb.sv
